/* rtl/core/assert_macros.svh */
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on the rising edge of clk_i, off while rst_ni is low
`define OA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every rising edge of clk_i, reset included
`define OA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* rtl/core/oaef_pkg.sv */
// types, codes and constants of the obstacle avoidance mode machine
package oaef_pkg;

  // field widths
  localparam int OP_W       = 2;
  localparam int DIST_W     = 20;
  localparam int TIME_W     = 32;
  localparam int STUCK_W    = 20;
  localparam int PHASE_MS_W = 16;
  localparam int HARD_W     = 12;
  localparam int SPEED_W    = 11;
  localparam int GAP_W      = 12;
  localparam int MODE_W     = 2;
  localparam int STREAK_W   = 2;
  localparam int LIN_W      = 12;
  localparam int ANG_W      = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // speed scaling datapath
  localparam int ALIGN_W   = 8;
  localparam int NUM_W     = SPEED_W + ALIGN_W;
  localparam int PROD_W    = NUM_W + DIST_W;
  localparam int DIVR_W    = DIST_W + ALIGN_W;
  localparam int QUO_W     = SPEED_W;
  localparam int DSH_W     = DIVR_W + QUO_W - 1;
  localparam int DIV_STEPS = QUO_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // divide by 250 as multiply and shift, exact for any dividend below 2^19
  localparam int                RECIP_SH    = 27;
  localparam logic [DIST_W-1:0] RECIP_ALIGN = 20'd536871;

  // operation codes
  localparam logic [OP_W-1:0] OP_SCAN  = 2'd0;
  localparam logic [OP_W-1:0] OP_DEPTH = 2'd1;
  localparam logic [OP_W-1:0] OP_CMD   = 2'd2;

  // mode codes
  localparam logic [MODE_W-1:0] MODE_NAV    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_AVOID  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ESCAPE = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CAUTION  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DANGER   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STUCK    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ESC_REV  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ESC_TURN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HARD     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LSPEED   = 3'd7;

  // register reset values
  localparam logic [DIST_W-1:0]     RST_CAUTION  = 20'd1500;
  localparam logic [DIST_W-1:0]     RST_CLEAR    = 20'd2000;
  localparam logic [DIST_W-1:0]     RST_DANGER   = 20'd500;
  localparam logic [STUCK_W-1:0]    RST_STUCK    = 20'd5000;
  localparam logic [PHASE_MS_W-1:0] RST_ESC_REV  = 16'd1500;
  localparam logic [PHASE_MS_W-1:0] RST_ESC_TURN = 16'd1500;
  localparam logic [HARD_W-1:0]     RST_HARD     = 12'd800;
  localparam logic [SPEED_W-1:0]    RST_LSPEED   = 11'd300;

  // behavior constants
  localparam logic [DIST_W-1:0]       FAR_MM             = 20'd999000;
  localparam logic [DIST_W:0]         STUCK_IMPROVE_MM   = 21'd200;
  localparam logic [STREAK_W-1:0]     CLEAR_NEEDED       = 2'd2;
  localparam logic [GAP_W-1:0]        ALIGN_TENTHS       = 12'd250;
  localparam logic signed [LIN_W-1:0] ESCAPE_REVERSE_MMS = -12'sd200;
  localparam logic signed [LIN_W-1:0] DANGER_CRAWL_MMS   = 12'sd30;
  localparam logic signed [LIN_W-1:0] MISALIGNED_MMS     = 12'sd20;
  localparam logic [QUO_W-1:0]        MIN_ALIGNED_MMS    = 11'd40;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic exec;
    logic mul;
    logic div_step;
    logic fix;
    logic out_load;
  } oaef_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;
    logic by_range;
  } oaef_sts_t;

endpackage

/* rtl/core/oaef_req_if.sv */
// request channel: one scan, depth or command item
interface oaef_req_if;
  import oaef_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic [DIST_W-1:0]        front_mm;
  logic [DIST_W-1:0]        left_avg_mm;
  logic [DIST_W-1:0]        right_avg_mm;
  logic signed [GAP_W-1:0]  gap_tenths;
  logic [TIME_W-1:0]        now_ms;

  modport source (
    output valid, operation, front_mm, left_avg_mm, right_avg_mm, gap_tenths, now_ms,
    input  ready
  );

  modport sink (
    input  valid, operation, front_mm, left_avg_mm, right_avg_mm, gap_tenths, now_ms,
    output ready
  );
endinterface

/* rtl/core/oaef_rsp_if.sv */
// result channel: mode, turn side and motion command
interface oaef_rsp_if;
  import oaef_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic                     turning_right;
  logic                     command_valid;
  logic signed [LIN_W-1:0]  linear_mms;
  logic signed [ANG_W-1:0]  angular_mrads;

  modport source (
    output valid, mode, turning_right, command_valid, linear_mms, angular_mrads,
    input  ready
  );

  modport sink (
    input  valid, mode, turning_right, command_valid, linear_mms, angular_mrads,
    output ready
  );
endinterface

/* rtl/core/oaef_ctrl.sv */
// sequencer: item intake, mode update, speed scaling steps and result hand-off
`include "assert_macros.svh"

module oaef_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  oaef_pkg::oaef_sts_t sts_i,
  output oaef_pkg::oaef_cmd_t cmd_o
);
  import oaef_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIX  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(DIV_STEPS - 1);

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             in_fire;
  logic             out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.load_item = in_fire;
    cmd_o.exec      = (state_q == S_EXEC);
    cmd_o.mul       = (state_q == S_MUL);
    cmd_o.div_step  = (state_q == S_DIV);
    cmd_o.fix       = (state_q == S_FIX);
    cmd_o.out_load  = (state_q == S_DONE) && out_free;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = sts_i.need_div ? S_MUL : S_DONE;
      end
      S_MUL: begin
        // range scaling needs the divider, plain alignment scaling is done here
        state_d = sts_i.by_range ? S_DIV : S_FIX;
        cnt_d   = CNT_TOP;
      end
      S_DIV: begin
        if (cnt_q == '0) begin
          state_d = S_FIX;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_FIX: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  `OA_ASSERT(a_fire_to_exec, in_fire |=> (state_q == S_EXEC), "accepted item did not start")
  `OA_ASSERT(a_mul_to_div, (state_q == S_MUL) |=> (cnt_q == CNT_TOP), "divider not armed")
  `OA_ASSERT(a_done_holds, ((state_q == S_DONE) && !out_free) |=> (state_q == S_DONE), "result dropped while output busy")

endmodule

/* rtl/core/oaef_dp.sv */
// datapath: registers, mode update, command logic, speed divider, output register
`include "assert_macros.svh"

module oaef_dp (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  oaef_pkg::oaef_cmd_t                     cmd_i,
  output oaef_pkg::oaef_sts_t                     sts_o,
  input  logic                                    cfg_we_i,
  input  logic [oaef_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [oaef_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  input  logic [oaef_pkg::OP_W-1:0]               op_i,
  input  logic [oaef_pkg::DIST_W-1:0]             front_i,
  input  logic [oaef_pkg::DIST_W-1:0]             left_i,
  input  logic [oaef_pkg::DIST_W-1:0]             right_i,
  input  logic signed [oaef_pkg::GAP_W-1:0]       gap_i,
  input  logic [oaef_pkg::TIME_W-1:0]             now_i,
  output logic [oaef_pkg::MODE_W-1:0]             mode_o,
  output logic                                    turn_right_o,
  output logic                                    cmd_valid_o,
  output logic signed [oaef_pkg::LIN_W-1:0]       lin_o,
  output logic signed [oaef_pkg::ANG_W-1:0]       ang_o
);
  import oaef_pkg::*;

  // configuration
  logic [DIST_W-1:0]     caution_q, clear_q, danger_q;
  logic [STUCK_W-1:0]    stuck_q;
  logic [PHASE_MS_W-1:0] esc_rev_q, esc_turn_q;
  logic [HARD_W-1:0]     hard_q;
  logic [SPEED_W-1:0]    lspd_q;

  // captured item
  logic [OP_W-1:0]         op_q;
  logic [DIST_W-1:0]       front_in_q, left_in_q, right_in_q;
  logic signed [GAP_W-1:0] gap_in_q;
  logic [TIME_W-1:0]       now_q;

  // mode machine state
  logic [MODE_W-1:0]       mode_q, mode_d;
  logic [STREAK_W-1:0]     streak_q, streak_d;
  logic [DIST_W-1:0]       front_min_q, front_min_d;
  logic [DIST_W-1:0]       left_q, left_d, right_q, right_d;
  logic signed [GAP_W-1:0] gap_q, gap_d;
  logic                    turn_q, turn_d;
  logic                    phase_q, phase_d;
  logic [DIST_W-1:0]       best_q, best_d;
  logic [TIME_W-1:0]       avoid_since_q, avoid_since_d;
  logic [TIME_W-1:0]       esc_since_q, esc_since_d;

  // result of the current item
  logic [MODE_W-1:0]       res_mode_q, res_mode_d;
  logic                    res_turn_q, res_turn_d;
  logic                    res_cv_q, res_cv_d;
  logic signed [LIN_W-1:0] res_lin_q, res_lin_d;
  logic signed [ANG_W-1:0] res_ang_q, res_ang_d;

  // speed scaling
  logic [NUM_W-1:0]  num_q, num_d;
  logic              use_cau_q, use_cau_d;
  logic [PROD_W-1:0] dvd_q, dvd_d;
  logic [DSH_W-1:0]  dsh_q, dsh_d;
  logic [QUO_W-1:0]  quo_q, quo_d;

  // output register
  logic [MODE_W-1:0]       out_mode_q;
  logic                    out_turn_q, out_cv_q;
  logic signed [LIN_W-1:0] out_lin_q;
  logic signed [ANG_W-1:0] out_ang_q;

  // combinational helpers
  logic                      upd, cmdx;
  logic [DIST_W-1:0]         fm, lv, rv;
  logic signed [GAP_W-1:0]   gv;
  logic                      blocked, improve, stuck_out;
  logic [DIST_W:0]           best_lim;
  logic [TIME_W-1:0]         since_u, esc_el;
  logic [STREAK_W-1:0]       streak_inc;
  logic                      danger;
  logic signed [ANG_W-1:0]   hard13, side;
  logic signed [GAP_W+1:0]   a4, hard14, ang_cl;
  logic [GAP_W-1:0]          mag;
  logic [ALIGN_W-1:0]        aln;
  logic                      need_div;
  logic [NUM_W-1:0]          num_x;
  logic [DIST_W-1:0]         mul_b;
  logic [PROD_W-1:0]         prod;
  logic [DIVR_W-1:0]         cau_w, divr;
  logic                      ge;

  // load the item fields, a depth item only when it lowers the front minimum
  always_comb begin
    upd  = 1'b0;
    cmdx = 1'b0;
    fm   = front_min_q;
    lv   = left_q;
    rv   = right_q;
    gv   = gap_q;
    if (cmd_i.exec) begin
      case (op_q)
        OP_SCAN: begin
          fm  = front_in_q;
          lv  = left_in_q;
          rv  = right_in_q;
          gv  = gap_in_q;
          upd = 1'b1;
        end
        OP_DEPTH: begin
          if (front_in_q < front_min_q) begin
            fm  = front_in_q;
            upd = 1'b1;
          end
        end
        OP_CMD: begin
          cmdx = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // mode update terms
  assign blocked    = (mode_q == MODE_NAV) ? (fm < caution_q) : (fm < clear_q);
  assign best_lim   = {1'b0, best_q} + STUCK_IMPROVE_MM;
  assign improve    = {1'b0, fm} > best_lim;
  assign since_u    = improve ? now_q : avoid_since_q;
  assign stuck_out  = (now_q - since_u) > TIME_W'(stuck_q);
  assign streak_inc = streak_q + 1'b1;

  // command terms
  assign danger = front_min_q < danger_q;
  assign hard13 = signed'({1'b0, hard_q});
  assign side   = turn_q ? -hard13 : hard13;
  assign esc_el = now_q - esc_since_q;
  assign a4     = {gap_q, 2'b00};
  assign hard14 = signed'({2'b00, hard_q});
  assign mag    = gap_q[GAP_W-1] ? GAP_W'(-gap_q) : gap_q;
  assign aln    = ALIGN_W'(ALIGN_TENTHS - mag);

  always_comb begin
    if (a4 > hard14) begin
      ang_cl = hard14;
    end else if (a4 < -hard14) begin
      ang_cl = -hard14;
    end else begin
      ang_cl = a4;
    end
  end

  always_comb begin
    mode_d        = mode_q;
    streak_d      = streak_q;
    front_min_d   = fm;
    left_d        = lv;
    right_d       = rv;
    gap_d         = gv;
    turn_d        = turn_q;
    phase_d       = phase_q;
    best_d        = best_q;
    avoid_since_d = avoid_since_q;
    esc_since_d   = esc_since_q;
    res_lin_d     = res_lin_q;
    res_ang_d     = res_ang_q;
    need_div      = 1'b0;

    if (upd) begin
      if (!blocked && (mode_q == MODE_AVOID)) begin
        // two clear updates in a row leave avoiding
        if (streak_inc >= CLEAR_NEEDED) begin
          mode_d   = MODE_NAV;
          best_d   = FAR_MM;
          streak_d = '0;
        end else begin
          streak_d = streak_inc;
        end
      end else begin
        streak_d = '0;
        if (blocked && (mode_q == MODE_NAV)) begin
          mode_d        = MODE_AVOID;
          avoid_since_d = now_q;
          best_d        = fm;
          turn_d        = rv > lv;
        end else if (mode_q == MODE_AVOID) begin
          // progress restarts the stuck timer
          best_d        = improve ? fm : best_q;
          avoid_since_d = since_u;
          if (stuck_out) begin
            mode_d      = MODE_ESCAPE;
            esc_since_d = now_q;
            phase_d     = 1'b0;
            turn_d      = !turn_q;
          end
        end
      end
    end

    if (cmd_i.exec) begin
      res_lin_d = '0;
      res_ang_d = '0;
    end

    if (cmdx) begin
      if (mode_q == MODE_ESCAPE) begin
        if (!phase_q) begin
          // reverse phase
          res_lin_d = ESCAPE_REVERSE_MMS;
          if (esc_el > TIME_W'(esc_rev_q)) begin
            phase_d     = 1'b1;
            esc_since_d = now_q;
          end
        end else begin
          // hard turn phase
          res_ang_d = side;
          if (esc_el > TIME_W'(esc_turn_q)) begin
            mode_d        = MODE_AVOID;
            avoid_since_d = now_q;
            best_d        = front_min_q;
            phase_d       = 1'b0;
          end
        end
      end else if (danger && (mode_q == MODE_AVOID)) begin
        // danger while avoiding: stop and escape toward the more open side
        mode_d      = MODE_ESCAPE;
        esc_since_d = now_q;
        phase_d     = 1'b0;
        streak_d    = '0;
        turn_d      = right_q > left_q;
      end else begin
        res_ang_d = danger ? side : ANG_W'(ang_cl);
        if (danger) begin
          res_lin_d = DANGER_CRAWL_MMS;
        end else if (mag < ALIGN_TENTHS) begin
          need_div = 1'b1;
        end else begin
          res_lin_d = MISALIGNED_MMS;
        end
      end
    end

    if (cmd_i.fix) begin
      res_lin_d = (quo_q < MIN_ALIGNED_MMS) ? LIN_W'(MIN_ALIGNED_MMS) :
                                              signed'({1'b0, quo_q});
    end
  end

  always_comb begin
    sts_o          = '0;
    sts_o.need_div = need_div;
    sts_o.by_range = use_cau_q;
  end

  assign res_mode_d = cmd_i.exec ? mode_d : res_mode_q;
  assign res_turn_d = cmd_i.exec ? turn_d : res_turn_q;
  assign res_cv_d   = cmd_i.exec ? cmdx   : res_cv_q;

  // speed scaling: num = speed * (250 - |gap|), then num * front / (250 * caution)
  // through the divider, or num / 250 by reciprocal multiply
  assign num_x     = lspd_q * aln;
  assign num_d     = cmd_i.exec ? num_x : num_q;
  assign use_cau_d = cmd_i.exec ? (front_min_q < caution_q) : use_cau_q;
  assign mul_b     = use_cau_q ? front_min_q : RECIP_ALIGN;
  assign prod      = num_q * mul_b;
  assign cau_w     = DIVR_W'(caution_q);
  assign divr      = (cau_w << 8) - (cau_w << 2) - (cau_w << 1);
  assign ge        = {1'b0, dsh_q} <= dvd_q;

  always_comb begin
    dvd_d = dvd_q;
    dsh_d = dsh_q;
    quo_d = quo_q;
    if (cmd_i.mul) begin
      if (use_cau_q) begin
        dvd_d = prod;
        dsh_d = {divr, {(QUO_W-1){1'b0}}};
        quo_d = '0;
      end else begin
        quo_d = prod[RECIP_SH +: QUO_W];
      end
    end else if (cmd_i.div_step) begin
      // one quotient bit per step, quotient known to fit
      dvd_d = ge ? (dvd_q - {1'b0, dsh_q}) : dvd_q;
      dsh_d = dsh_q >> 1;
      quo_d = {quo_q[QUO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      caution_q     <= RST_CAUTION;
      clear_q       <= RST_CLEAR;
      danger_q      <= RST_DANGER;
      stuck_q       <= RST_STUCK;
      esc_rev_q     <= RST_ESC_REV;
      esc_turn_q    <= RST_ESC_TURN;
      hard_q        <= RST_HARD;
      lspd_q        <= RST_LSPEED;
      mode_q        <= MODE_NAV;
      streak_q      <= '0;
      front_min_q   <= FAR_MM;
      left_q        <= FAR_MM;
      right_q       <= FAR_MM;
      gap_q         <= '0;
      turn_q        <= 1'b0;
      phase_q       <= 1'b0;
      best_q        <= FAR_MM;
      avoid_since_q <= '0;
      esc_since_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CAUTION:  caution_q  <= cfg_data_i;
          REG_CLEAR:    clear_q    <= cfg_data_i;
          REG_DANGER:   danger_q   <= cfg_data_i;
          REG_STUCK:    stuck_q    <= cfg_data_i;
          REG_ESC_REV:  esc_rev_q  <= cfg_data_i[PHASE_MS_W-1:0];
          REG_ESC_TURN: esc_turn_q <= cfg_data_i[PHASE_MS_W-1:0];
          REG_HARD:     hard_q     <= cfg_data_i[HARD_W-1:0];
          REG_LSPEED:   lspd_q     <= cfg_data_i[SPEED_W-1:0];
          default: begin
          end
        endcase
      end
      mode_q        <= mode_d;
      streak_q      <= streak_d;
      front_min_q   <= front_min_d;
      left_q        <= left_d;
      right_q       <= right_d;
      gap_q         <= gap_d;
      turn_q        <= turn_d;
      phase_q       <= phase_d;
      best_q        <= best_d;
      avoid_since_q <= avoid_since_d;
      esc_since_q   <= esc_since_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q       <= op_i;
      front_in_q <= front_i;
      left_in_q  <= left_i;
      right_in_q <= right_i;
      gap_in_q   <= gap_i;
      now_q      <= now_i;
    end
    res_mode_q <= res_mode_d;
    res_turn_q <= res_turn_d;
    res_cv_q   <= res_cv_d;
    res_lin_q  <= res_lin_d;
    res_ang_q  <= res_ang_d;
    num_q      <= num_d;
    use_cau_q  <= use_cau_d;
    dvd_q      <= dvd_d;
    dsh_q      <= dsh_d;
    quo_q      <= quo_d;
    if (cmd_i.out_load) begin
      out_mode_q <= res_mode_q;
      out_turn_q <= res_turn_q;
      out_cv_q   <= res_cv_q;
      out_lin_q  <= res_lin_q;
      out_ang_q  <= res_ang_q;
    end
  end

  assign mode_o       = out_mode_q;
  assign turn_right_o = out_turn_q;
  assign cmd_valid_o  = out_cv_q;
  assign lin_o        = out_lin_q;
  assign ang_o        = out_ang_q;

  `OA_ASSERT(a_phase_in_escape, phase_q |-> (mode_q == MODE_ESCAPE), "turn phase outside escaping")
  `OA_ASSERT(a_streak_low, streak_q < CLEAR_NEEDED, "clear streak not cleared on exit")
  `OA_ASSERT(a_cmd_flagged, (cmd_i.exec && (op_q == OP_CMD)) |=> res_cv_q, "command result not flagged")

endmodule

/* rtl/core/obstacle_avoid_escape_fsm_unit.sv */
// top level of the rover obstacle avoidance mode machine
//
//  channel  dir  handshake        carries
//  req_i    in   valid / ready    operation, front, side averages, gap, time
//  rsp_o    out  valid / ready    mode, turn side, command flag, linear, angular
//  cfg      in   cfg_we_i only    eight threshold and speed registers
//
// one request at a time: scan, depth and unscaled commands go through the
// update and done steps, a command scaled by gap alignment only adds one
// reciprocal multiply and a clamp step, one also scaled by front range adds
// the multiply, the 11-step restoring divider and the clamp
// the result sits in an output register so the next request is taken while
// it waits; a stalled rsp_o holds the following result in the done step
// reset clears the mode state, the registers to their defaults and the output valid

module obstacle_avoid_escape_fsm_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [oaef_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [oaef_pkg::CFG_DATA_W-1:0] cfg_data_i,
  oaef_req_if.sink                        req_i,
  oaef_rsp_if.source                      rsp_o
);
  import oaef_pkg::*;

  oaef_cmd_t cmd;
  oaef_sts_t sts;

  // sequencer: intake, update, multiply, divide, clamp and hand-off steps
  oaef_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // mode state, thresholds, arithmetic and the output register
  oaef_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .op_i         (req_i.operation),
    .front_i      (req_i.front_mm),
    .left_i       (req_i.left_avg_mm),
    .right_i      (req_i.right_avg_mm),
    .gap_i        (req_i.gap_tenths),
    .now_i        (req_i.now_ms),
    .mode_o       (rsp_o.mode),
    .turn_right_o (rsp_o.turning_right),
    .cmd_valid_o  (rsp_o.command_valid),
    .lin_o        (rsp_o.linear_mms),
    .ang_o        (rsp_o.angular_mrads)
  );

endmodule

/* bench/tb_top.sv */
// self-checking bench for the rover obstacle avoidance mode machine
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import oaef_pkg::*;

  // bench constants
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;  // spare operation code, reports the mode and turn side only
  localparam int NUM_REGS      = 8;
  localparam int STEER_GAIN    = 4;        // mrad/s per tenth of a degree of gap
  localparam int SETTLE_CYCLES = 24;       // longer than the slowest request
  localparam int LONG_HOLD     = 200;      // output stall long enough to back up the input
  localparam int MAX_REPORTS   = 40;
  localparam int RUN_LIMIT_NS  = 2_000_000;

  // request as the sender sees it
  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic [DIST_W-1:0]       front;
    logic [DIST_W-1:0]       left;
    logic [DIST_W-1:0]       right;
    logic signed [GAP_W-1:0] gap;
    logic [TIME_W-1:0]       now;
  } nav_req_t;

  // one result as it leaves the block
  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic                    turning_right;
    logic                    command_valid;
    logic signed [LIN_W-1:0] linear_mms;
    logic signed [ANG_W-1:0] angular_mrads;
  } nav_rsp_t;

  // threshold and speed registers
  typedef struct {
    logic [DIST_W-1:0]     caution;
    logic [DIST_W-1:0]     clear;
    logic [DIST_W-1:0]     danger;
    logic [STUCK_W-1:0]    stuck;
    logic [PHASE_MS_W-1:0] rev;
    logic [PHASE_MS_W-1:0] turn;
    logic [HARD_W-1:0]     hard;
    logic [SPEED_W-1:0]    lspeed;
  } limits_t;

  // mode machine state kept by the bench
  typedef struct {
    logic [MODE_W-1:0]       mode;
    logic [STREAK_W-1:0]     streak;
    logic [DIST_W-1:0]       front;
    logic [DIST_W-1:0]       left;
    logic [DIST_W-1:0]       right;
    logic signed [GAP_W-1:0] gap;
    logic                    go_right;
    logic                    turning;     // escape sub-phase: 0 reversing, 1 hard turn
    logic [DIST_W-1:0]       best;
    logic [TIME_W-1:0]       avoid_t0;
    logic [TIME_W-1:0]       escape_t0;
  } rover_state_t;

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_ni;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // register write port
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  oaef_req_if req ();
  oaef_rsp_if rsp ();

  obstacle_avoid_escape_fsm_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req_i      (req),
    .rsp_o      (rsp)
  );

  // bench-side copy of the machine
  rover_state_t st;
  limits_t      lim;

  // results still owed by the block, oldest first
  nav_rsp_t pending_results[$];

  int mismatches   = 0;
  int results_seen = 0;

  // pacing and traffic shaping
  int          sender_max_gap = 6;
  int          burst_left     = 0;
  int          hold_request   = 0;
  int unsigned step_ms        = 1000;
  logic [TIME_W-1:0] clock_ms = '0;
  logic [DIST_W-1:0] obstacle_mm = FAR_MM;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic void reset_rover();
    lim.caution = RST_CAUTION;
    lim.clear   = RST_CLEAR;
    lim.danger  = RST_DANGER;
    lim.stuck   = RST_STUCK;
    lim.rev     = RST_ESC_REV;
    lim.turn    = RST_ESC_TURN;
    lim.hard    = RST_HARD;
    lim.lspeed  = RST_LSPEED;
    st.mode      = MODE_NAV;
    st.streak    = '0;
    st.front     = FAR_MM;
    st.left      = FAR_MM;
    st.right     = FAR_MM;
    st.gap       = '0;
    st.go_right  = 1'b0;
    st.turning   = 1'b0;
    st.best      = FAR_MM;
    st.avoid_t0  = '0;
    st.escape_t0 = '0;
  endfunction

  // hysteresis, clear streak and stuck timer after new range data
  function automatic void update_mode(input logic [TIME_W-1:0] now);
    logic              blocked;
    logic [TIME_W-1:0] waited;
    // enter on caution, leave only at or above clear
    blocked = (st.mode == MODE_NAV) ? (st.front < lim.caution) : (st.front < lim.clear);

    if (!blocked && st.mode == MODE_AVOID) begin
      st.streak = st.streak + 1'b1;
      if (st.streak >= CLEAR_NEEDED) begin
        st.mode   = MODE_NAV;
        st.best   = FAR_MM;
        st.streak = '0;
      end
      return;
    end
    st.streak = '0;

    if (blocked && st.mode == MODE_NAV) begin
      st.mode     = MODE_AVOID;
      st.avoid_t0 = now;
      st.best     = st.front;
      st.go_right = st.right > st.left;
      return;
    end

    if (st.mode == MODE_AVOID) begin
      // real progress restarts the stuck timer
      if (st.front > st.best + STUCK_IMPROVE_MM) begin
        st.best     = st.front;
        st.avoid_t0 = now;
      end
      waited = now - st.avoid_t0;
      if (waited > TIME_W'(lim.stuck)) begin
        st.mode      = MODE_ESCAPE;
        st.escape_t0 = now;
        st.turning   = 1'b0;
        st.streak    = '0;
        st.go_right  = !st.go_right;
      end
    end
  endfunction

  // motion command: escape phases, danger trigger, gap steering
  function automatic nav_rsp_t drive_command(input logic [TIME_W-1:0] now);
    nav_rsp_t          o;
    int                hard;
    int                side;
    int                rate;
    int                mag;
    logic              danger;
    logic [TIME_W-1:0] elapsed;
    longint unsigned   speed;
    o      = '0;
    hard   = int'(lim.hard);
    side   = st.go_right ? -hard : hard;
    danger = st.front < lim.danger;

    if (st.mode == MODE_ESCAPE) begin
      elapsed = now - st.escape_t0;
      if (!st.turning) begin
        o.linear_mms = ESCAPE_REVERSE_MMS;
        if (elapsed > TIME_W'(lim.rev)) begin
          st.turning   = 1'b1;
          st.escape_t0 = now;
        end
      end else begin
        o.angular_mrads = ANG_W'(side);
        if (elapsed > TIME_W'(lim.turn)) begin
          st.mode     = MODE_AVOID;
          st.avoid_t0 = now;
          st.best     = st.front;
          st.turning  = 1'b0;
        end
      end
      return o;
    end

    if (danger && st.mode == MODE_AVOID) begin
      st.mode      = MODE_ESCAPE;
      st.escape_t0 = now;
      st.turning   = 1'b0;
      st.streak    = '0;
      st.go_right  = st.right > st.left;
      return o;
    end

    rate = STEER_GAIN * int'(st.gap);
    mag  = (st.gap < 0) ? -int'(st.gap) : int'(st.gap);
    if (rate > hard) rate = hard;
    if (rate < -hard) rate = -hard;
    if (danger) rate = side;
    o.angular_mrads = ANG_W'(rate);

    if (danger) begin
      o.linear_mms = DANGER_CRAWL_MMS;
    end else if (mag < int'(ALIGN_TENTHS)) begin
      speed = 64'(lim.lspeed) * 64'(int'(ALIGN_TENTHS) - mag);
      // near an obstacle the speed also scales with the front range, one division
      if (st.front < lim.caution) begin
        speed = (speed * 64'(st.front)) / (64'(ALIGN_TENTHS) * 64'(lim.caution));
      end else begin
        speed = speed / 64'(ALIGN_TENTHS);
      end
      if (speed < 64'(MIN_ALIGNED_MMS)) speed = 64'(MIN_ALIGNED_MMS);
      o.linear_mms = LIN_W'(speed);
    end else begin
      o.linear_mms = MISALIGNED_MMS;
    end
    return o;
  endfunction

  // full effect of one accepted request
  function automatic nav_rsp_t step_rover(input nav_req_t r);
    nav_rsp_t o;
    o = '0;
    case (r.op)
      OP_SCAN: begin
        st.front = r.front;
        st.left  = r.left;
        st.right = r.right;
        st.gap   = r.gap;
        update_mode(r.now);
      end
      OP_DEPTH: begin
        // depth only ever lowers the front minimum
        if (r.front < st.front) begin
          st.front = r.front;
          update_mode(r.now);
        end
      end
      OP_CMD: begin
        o = drive_command(r.now);
        o.command_valid = 1'b1;
      end
      default: ;
    endcase
    o.mode          = st.mode;
    o.turning_right = st.go_right;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic nav_req_t mk_req(input logic [OP_W-1:0] op, input int unsigned front,
                                      input int unsigned left, input int unsigned right,
                                      input int gap, input logic [TIME_W-1:0] now);
    nav_req_t r;
    r.op    = op;
    r.front = DIST_W'(front);
    r.left  = DIST_W'(left);
    r.right = DIST_W'(right);
    r.gap   = GAP_W'(gap);
    r.now   = now;
    return r;
  endfunction

  function automatic limits_t mk_limits(input int unsigned caution, input int unsigned clear,
                                        input int unsigned danger, input int unsigned stuck,
                                        input int unsigned rev, input int unsigned turn,
                                        input int unsigned hard, input int unsigned lspeed);
    limits_t s;
    s.caution = DIST_W'(caution);
    s.clear   = DIST_W'(clear);
    s.danger  = DIST_W'(danger);
    s.stuck   = STUCK_W'(stuck);
    s.rev     = PHASE_MS_W'(rev);
    s.turn    = PHASE_MS_W'(turn);
    s.hard    = HARD_W'(hard);
    s.lspeed  = SPEED_W'(lspeed);
    return s;
  endfunction

  function automatic limits_t random_limits(input bit full_range);
    limits_t s;
    if (full_range) begin
      s.caution = DIST_W'($urandom_range(0, FAR_MM));
      s.clear   = DIST_W'($urandom_range(0, FAR_MM));
      s.danger  = DIST_W'($urandom_range(0, FAR_MM));
      s.stuck   = STUCK_W'($urandom_range(0, 600000));
      s.rev     = PHASE_MS_W'($urandom_range(0, 60000));
      s.turn    = PHASE_MS_W'($urandom_range(0, 60000));
    end else begin
      s.caution = DIST_W'($urandom_range(0, 6000));
      s.clear   = DIST_W'($urandom_range(0, 9000));
      s.danger  = DIST_W'($urandom_range(0, 3000));
      s.stuck   = STUCK_W'($urandom_range(0, 8000));
      s.rev     = PHASE_MS_W'($urandom_range(0, 3000));
      s.turn    = PHASE_MS_W'($urandom_range(0, 3000));
    end
    s.hard   = HARD_W'($urandom_range(0, 4000));
    s.lspeed = SPEED_W'($urandom_range(0, 2000));
    return s;
  endfunction

  // base moved by up to +-span, kept inside the range field
  function automatic logic [DIST_W-1:0] nudge(input int base, input int span);
    int v;
    v = base + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > int'(FAR_MM)) v = int'(FAR_MM);
    return DIST_W'(v);
  endfunction

  // range values cluster around the live thresholds
  function automatic logic [DIST_W-1:0] near_threshold();
    case ($urandom_range(0, 5))
      0:       return nudge(int'(lim.danger), 300);
      1:       return nudge(int'(lim.caution), 300);
      2:       return nudge(int'(lim.clear), 300);
      3:       return nudge(int'(lim.clear) + 400, 400);
      4:       return DIST_W'($urandom_range(0, FAR_MM));
      default: return FAR_MM;
    endcase
  endfunction

  // mostly a plausible drive: time moves forward, the obstacle drifts slowly;
  // a few time jumps and wild readings as noise
  function automatic nav_req_t random_request();
    nav_req_t    r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      clock_ms = $urandom();
    end else begin
      clock_ms = clock_ms + $urandom_range(0, step_ms);
    end
    r.now   = clock_ms;
    r.front = DIST_W'($urandom_range(0, FAR_MM));
    r.left  = DIST_W'($urandom_range(0, FAR_MM));
    r.right = DIST_W'($urandom_range(0, FAR_MM));
    r.gap   = GAP_W'(int'($urandom_range(0, 3600)) - 1800);

    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      r.op = OP_SCAN;
      if ($urandom_range(0, 99) < 15) begin
        obstacle_mm = near_threshold();
      end else begin
        // small drift, usually less than the stuck improvement step
        obstacle_mm = nudge(int'(obstacle_mm), 150);
      end
      if ($urandom_range(0, 99) < 85) r.front = obstacle_mm;
      if ($urandom_range(0, 1) == 0) begin
        r.left  = nudge(int'(obstacle_mm), 500);
        r.right = nudge(int'(obstacle_mm), 500);
      end
      if ($urandom_range(0, 1) == 0) r.gap = GAP_W'(int'($urandom_range(0, 600)) - 300);
    end else if (pick < 85) begin
      r.op = OP_CMD;
    end else if (pick < 96) begin
      r.op = OP_DEPTH;
      if ($urandom_range(0, 99) < 70) r.front = DIST_W'($urandom_range(0, st.front));
    end else begin
      r.op = OP_UNUSED;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------------

  // offer one request, return once it is taken; the expected result is
  // recorded at the accepting edge
  task automatic send_request(input nav_req_t r);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, sender_max_gap);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    req.valid        <= 1'b1;
    req.operation    <= r.op;
    req.front_mm     <= r.front;
    req.left_avg_mm  <= r.left;
    req.right_avg_mm <= r.right;
    req.gap_tenths   <= r.gap;
    req.now_ms       <= r.now;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    pending_results.push_back(step_rover(r));
  endtask

  // stop offering and let every owed result come out
  task automatic wait_drained();
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write all eight registers back to back, only while the block is idle
  task automatic load_limits(input limits_t s);
    logic [CFG_DATA_W-1:0] vals [NUM_REGS];
    vals[REG_CAUTION]  = CFG_DATA_W'(s.caution);
    vals[REG_CLEAR]    = CFG_DATA_W'(s.clear);
    vals[REG_DANGER]   = CFG_DATA_W'(s.danger);
    vals[REG_STUCK]    = CFG_DATA_W'(s.stuck);
    vals[REG_ESC_REV]  = CFG_DATA_W'(s.rev);
    vals[REG_ESC_TURN] = CFG_DATA_W'(s.turn);
    vals[REG_HARD]     = CFG_DATA_W'(s.hard);
    vals[REG_LSPEED]   = CFG_DATA_W'(s.lspeed);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= CFG_IDX_W'(i);
      cfg_data <= vals[i];
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
    lim = s;
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch at result %0d: %s got %0d want %0d", results_seen, what, got, want);
    end
  endtask

  // receiver: windows of random stall density, plus the long hold on demand
  initial begin : rsp_pacing
    int hold_left;
    int window;
    int stall_pct;
    hold_left = 0;
    window    = 0;
    stall_pct = 0;
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (window == 0) begin
        window = $urandom_range(8, 80);
        case ($urandom_range(0, 4))
          0, 1:    stall_pct = 0;
          2:       stall_pct = 25;
          3:       stall_pct = 55;
          default: stall_pct = 85;
        endcase
      end
      window--;
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // compare every accepted result with the oldest owed one, field by field
  always @(posedge clk_i) begin : check_results
    nav_rsp_t want;
    if (rst_ni && rsp.valid && rsp.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unrequested result, mode", int'(rsp.mode), -1);
      end else begin
        want = pending_results.pop_front();
        if (rsp.mode !== want.mode)
          report_mismatch("mode", int'(rsp.mode), int'(want.mode));
        if (rsp.turning_right !== want.turning_right)
          report_mismatch("turning_right", int'(rsp.turning_right), int'(want.turning_right));
        if (rsp.command_valid !== want.command_valid)
          report_mismatch("command_valid", int'(rsp.command_valid), int'(want.command_valid));
        if (rsp.linear_mms !== want.linear_mms)
          report_mismatch("linear_mms", int'(rsp.linear_mms), int'(want.linear_mms));
        if (rsp.angular_mrads !== want.angular_mrads)
          report_mismatch("angular_mrads", int'(rsp.angular_mrads), int'(want.angular_mrads));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // zero caution and clear: the machine stays navigating even inside danger,
  // so the crawl, the clamp and the alignment floor show in plain steering
  task automatic test_zero_caution();
    wait_drained();
    load_limits(mk_limits(0, 0, 500, 0, 0, 0, 4000, 2000));
    send_request(mk_req(OP_SCAN, 100, 5, 9, 1800, 10));
    send_request(mk_req(OP_CMD, 0, 0, 0, 0, 20));           // danger crawl, hard side
    send_request(mk_req(OP_SCAN, FAR_MM, 9, 5, -1800, 30));
    send_request(mk_req(OP_CMD, 0, 0, 0, 0, 40));           // clamp to -hard, misaligned
    send_request(mk_req(OP_SCAN, FAR_MM, 9, 5, 249, 50));
    send_request(mk_req(OP_CMD, 0, 0, 0, 0, 60));           // just aligned, floor of 40
    send_request(mk_req(OP_SCAN, FAR_MM, 9, 5, -250, 70));
    send_request(mk_req(OP_CMD, 0, 0, 0, 0, 80));           // just misaligned
    send_request(mk_req(OP_SCAN, FAR_MM, 9, 5, 0, 90));
    send_request(mk_req(OP_CMD, 0, 0, 0, 0, 100));          // full nominal speed
  endtask

  // navigating -> avoiding -> two clear scans -> navigating -> avoiding ->
  // stuck timer -> escape reverse -> hard turn -> back to avoiding, with default registers
  task automatic test_mode_walkthrough();
    wait_drained();
    load_limits(mk_limits(RST_CAUTION, RST_CLEAR, RST_DANGER, RST_STUCK,
                          RST_ESC_REV, RST_ESC_TURN, RST_HARD, RST_LSPEED));
    send_request(mk_req(OP_CMD, 0, 0, 0, 0, 0));
    send_request(mk_req(OP_SCAN, 1200, 800, 900, 100, 100));    // enter avoiding, right side
    send_request(mk_req(OP_CMD, 0, 0, 0, 0, 200));              // speed scaled by range
    send_request(mk_req(OP_SCAN, 2500, 800, 900, 100, 300));    // first clear scan
    send_request(mk_req(OP_SCAN, 2500, 800, 900, 100, 400));    // second clear, navigating
    send_request(mk_req(OP_SCAN, 1400, 2000, 1000, 0, 500));    // enter avoiding, left side
    send_request(mk_req(OP_SCAN, 1500, 2000, 1000, 0, 3000));   // no real progress
    send_request(mk_req(OP_SCAN, 1700, 2000, 1000, 0, 5000));   // progress restarts timer
    send_request(mk_req(OP_SCAN, 1700, 2000, 1000, 0, 10001));  // stuck, escape, flip side
    send_request(mk_req(OP_CMD, 0, 0, 0, 0, 10500));            // reversing
    send_request(mk_req(OP_CMD, 0, 0, 0, 0, 11502));            // reverse ends
    send_request(mk_req(OP_CMD, 0, 0, 0, 0, 12000));            // hard turn
    send_request(mk_req(OP_CMD, 0, 0, 0, 0, 13003));            // turn ends, avoiding
  endtask

  // depth that does not lower, depth that does, danger trigger, spare code
  task automatic test_depth_danger_spare();
    send_request(mk_req(OP_DEPTH, 2000, 0, 0, 0, 13100));
    send_request(mk_req(OP_DEPTH, 400, 0, 0, 0, 13200));
    send_request(mk_req(OP_CMD, 0, 0, 0, 0, 13300));            // danger while avoiding
    send_request(mk_req(OP_UNUSED, FAR_MM, FAR_MM, FAR_MM, -1, 13400));
  endtask

  // random traffic under one register setting
  task automatic test_random_traffic(input limits_t s, input int items,
                                     input int unsigned step, input logic [TIME_W-1:0] t0,
                                     input int max_gap);
    nav_req_t r;
    int       counted;
    wait_drained();
    load_limits(s);
    step_ms        = step;
    clock_ms       = t0;
    sender_max_gap = max_gap;
    obstacle_mm    = near_threshold();
    counted        = 0;
    while (counted < items) begin
      r = random_request();
      send_request(r);
      if (r.op != OP_UNUSED) counted++;
    end
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_output_backup();
    int saved_gap;
    saved_gap      = sender_max_gap;
    sender_max_gap = 0;
    hold_request   = LONG_HOLD;
    repeat (30) send_request(random_request());
    // sender pauses until everything owed has come back
    wait_drained();
    sender_max_gap = saved_gap;
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_data         = '0;
    req.valid        = 1'b0;
    req.operation    = OP_SCAN;
    req.front_mm     = '0;
    req.left_avg_mm  = '0;
    req.right_avg_mm = '0;
    req.gap_tenths   = '0;
    req.now_ms       = '0;
    reset_rover();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_zero_caution();
    test_mode_walkthrough();
    test_depth_danger_spare();

    // reset values, everyday timing
    test_random_traffic(mk_limits(RST_CAUTION, RST_CLEAR, RST_DANGER, RST_STUCK,
                                  RST_ESC_REV, RST_ESC_TURN, RST_HARD, RST_LSPEED),
                        260, 1500, 32'd20000, 6);
    // short timers, time wraps through zero, sender never idles
    test_random_traffic(mk_limits(1000, 1500, 400, 300, 200, 200, 1000, 500),
                        260, 300, 32'hFFFF_C000, 0);
    test_output_backup();
    // every register at its low end
    test_random_traffic(mk_limits(0, 0, 0, 0, 0, 0, 0, 0), 150, 50, 32'd7, 4);
    // every register at its high end
    test_random_traffic(mk_limits(999000, 999000, 999000, 600000, 60000, 60000, 4000, 2000),
                        150, 20000, 32'h8000_0000, 8);
    test_random_traffic(random_limits(1'b0), 180, 800, $urandom(), 3);
    test_random_traffic(random_limits(1'b0), 180, 1200, $urandom(), 10);
    test_random_traffic(random_limits(1'b1), 180, 40000, $urandom(), 5);

    wait_drained();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(RUN_LIMIT_NS);
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* obstacle_avoid_escape_fsm_unit.f */
+incdir+rtl/core
rtl/core/oaef_pkg.sv
rtl/core/oaef_req_if.sv
rtl/core/oaef_rsp_if.sv
rtl/core/oaef_ctrl.sv
rtl/core/oaef_dp.sv
rtl/core/obstacle_avoid_escape_fsm_unit.sv
bench/tb_top.sv
